// ===== design/ptfs_pkg.sv =====
// Shared types and constants for the priority task flag scheduler.
package ptfs_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 8;
  localparam int RUN_W     = 6;
  localparam int CNT_W     = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_FLAG    = 2'd2,
    REQ_SERVICE = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          op;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [RUN_W-1:0]  run_slot;
  } res_t;

  typedef struct packed {
    logic                  found;
    logic [NUM_SLOTS-1:0]  onehot;
    logic [IDX_W-1:0]      idx;
  } pick_t;

endpackage

// ===== design/ptfs_pick.sv =====
// Fixed-priority picker: lowest-numbered pending slot.
module ptfs_pick (
  input  logic [ptfs_pkg::NUM_SLOTS-1:0] pend,
  output ptfs_pkg::pick_t                pick
);

  always_comb begin
    pick.found  = |pend;
    pick.onehot = pend & (~pend + 1'b1);
    pick.idx    = '0;
    for (int i = ptfs_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick.idx = ptfs_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/ptfs_table.sv =====
// Slot table: occupied bits, pending counters and their per-transaction update.
module ptfs_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ptfs_pkg::req_t  req,
  output ptfs_pkg::res_t  res
);

  logic [ptfs_pkg::NUM_SLOTS-1:0] used;
  logic [ptfs_pkg::NUM_SLOTS-1:0] used_next;
  logic [ptfs_pkg::CNT_W-1:0]     cnt      [ptfs_pkg::NUM_SLOTS];
  logic [ptfs_pkg::CNT_W-1:0]     cnt_next [ptfs_pkg::NUM_SLOTS];
  logic [ptfs_pkg::NUM_SLOTS-1:0] pend;
  logic [ptfs_pkg::NUM_SLOTS-1:0] hit;
  logic [ptfs_pkg::NUM_SLOTS-1:0] stray;
  logic                           in_range;
  logic                           hit_used;
  ptfs_pkg::pick_t                pick;

  assign in_range = req.slot < ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS);

  always_comb begin
    for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
      pend[i]  = used[i] && (cnt[i] != '0);
      stray[i] = !used[i] && (cnt[i] != '0);
      hit[i]   = in_range && (req.slot[ptfs_pkg::IDX_W-1:0] == ptfs_pkg::IDX_W'(i));
    end
    hit_used = |(hit & used);
  end

  ptfs_pick u_pick (
    .pend (pend),
    .pick (pick)
  );

  always_comb begin
    used_next = used;
    res       = '0;
    for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
      cnt_next[i] = cnt[i];
    end
    unique case (req.op)
      ptfs_pkg::REQ_ADD: begin
        if (in_range && !hit_used) begin
          used_next    = used | hit;
          res.accepted = 1'b1;
        end
      end
      ptfs_pkg::REQ_REMOVE: begin
        used_next = used & ~hit;
        for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
          if (hit[i]) begin
            cnt_next[i] = '0;
          end
        end
      end
      ptfs_pkg::REQ_FLAG: begin
        res.accepted = hit_used;
        for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
          if (hit[i] && used[i] && cnt[i] != ptfs_pkg::CNT_MAX) begin
            cnt_next[i] = cnt[i] + 1'b1;
          end
        end
      end
      ptfs_pkg::REQ_SERVICE: begin
        res.accepted = pick.found;
        res.run_slot = ptfs_pkg::RUN_W'(pick.idx);
        for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
          if (pick.onehot[i]) begin
            cnt_next[i] = cnt[i] - 1'b1;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
        cnt[i] <= '0;
      end
    end else if (en) begin
      used <= used_next;
      for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

  // a free slot never holds pending work
  a_no_stray: assert property (@(posedge clk) disable iff (rst) stray == '0)
    else $error("pending count on free slot");

endmodule

// ===== design/priority_task_flag_scheduler.sv =====
// Top level of the priority task flag scheduler.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_type, slot
//   res      out  res_valid/res_stall   accepted, run_slot
//
// One transaction per cycle sustained while res_stall is low; a request passes
// the input register, then the table update and the result register.
// Reset (rst, synchronous) empties both registers and clears the slot table.
// A full input register stalls req only while the result register is held.
module priority_task_flag_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   req_type,
  input  logic [ptfs_pkg::SLOT_W-1:0]  slot,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         accepted,
  output logic [ptfs_pkg::RUN_W-1:0]   run_slot
);

  logic            req_v;
  ptfs_pkg::req_t  req_q;
  logic            process;
  ptfs_pkg::res_t  res;

  assign process   = req_v && (!res_valid || !res_stall);
  assign req_stall = req_v && !process;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else if (!req_stall) begin
      req_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q.op   <= ptfs_pkg::req_type_t'(req_type);
      req_q.slot <= slot;
    end
  end

  ptfs_table u_table (
    .clk (clk),
    .rst (rst),
    .en  (process),
    .req (req_q),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (process) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      accepted <= res.accepted;
      run_slot <= res.run_slot;
    end
  end

  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !accepted |-> run_slot == '0)
    else $error("run_slot set on rejected transaction");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> run_slot < ptfs_pkg::RUN_W'(ptfs_pkg::NUM_SLOTS))
    else $error("run_slot out of range");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> req_v && res_valid)
    else $error("req stalled with nothing held");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the priority task flag scheduler.
`timescale 1ns / 1ps

class sched_scoreboard;
  bit                       used [ptfs_pkg::NUM_SLOTS];
  bit [ptfs_pkg::CNT_W-1:0] pend [ptfs_pkg::NUM_SLOTS];
  ptfs_pkg::res_t           expected [$];
  int                       fails;

  function void note_request(ptfs_pkg::req_type_t op, logic [ptfs_pkg::SLOT_W-1:0] s);
    ptfs_pkg::res_t r;
    bit             hit;
    int             k;
    r = '0;
    hit = (s < ptfs_pkg::NUM_SLOTS);
    k = s;
    case (op)
      ptfs_pkg::REQ_ADD: begin
        if (hit && !used[k]) begin
          used[k] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      ptfs_pkg::REQ_REMOVE: begin
        if (hit && used[k]) begin
          used[k] = 1'b0;
          pend[k] = '0;
        end
      end
      ptfs_pkg::REQ_FLAG: begin
        if (hit && used[k]) begin
          if (pend[k] != ptfs_pkg::CNT_MAX) pend[k] = pend[k] + 1'b1;
          r.accepted = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < ptfs_pkg::NUM_SLOTS; i++) begin
          if (used[i] && pend[i] != 0) begin
            pend[i] = pend[i] - 1'b1;
            r.accepted = 1'b1;
            r.run_slot = ptfs_pkg::RUN_W'(i);
            break;
          end
        end
      end
    endcase
    expected.push_back(r);
  endfunction

  function void check_result(logic acc, logic [ptfs_pkg::RUN_W-1:0] run);
    ptfs_pkg::res_t e;
    if (expected.size() == 0) begin
      $error("result with nothing outstanding: accepted %0d run_slot %0d", acc, run);
      fails++;
      return;
    end
    e = expected.pop_front();
    if (acc !== e.accepted) begin
      $error("accepted: expected %0d, actual %0d", e.accepted, acc);
      fails++;
    end
    if (run !== e.run_slot) begin
      $error("run_slot: expected %0d, actual %0d", e.run_slot, run);
      fails++;
    end
  endfunction
endclass

module tb;
  localparam int WATCHDOG = 2000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic [1:0]                  req_type = ptfs_pkg::REQ_ADD;
  logic [ptfs_pkg::SLOT_W-1:0] slot = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic                        accepted;
  logic [ptfs_pkg::RUN_W-1:0]  run_slot;

  sched_scoreboard sb = new;
  bit quiet = 1'b0;
  int stall_left = 0;
  bit stall_now = 1'b0;
  int idle_cycles = 0;

  priority_task_flag_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .slot      (slot),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .accepted  (accepted),
    .run_slot  (run_slot)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(ptfs_pkg::req_type_t op, logic [ptfs_pkg::SLOT_W-1:0] s);
    int gap;
    gap = quiet ? 0 : pick_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    slot      <= s;
    do @(posedge clk); while (req_stall);
    sb.note_request(op, s);
  endtask

  task automatic send_random();
    ptfs_pkg::req_type_t         op;
    logic [ptfs_pkg::SLOT_W-1:0] s;
    int                          r;
    r = $urandom_range(0, 99);
    if (r < 25)      op = ptfs_pkg::REQ_ADD;
    else if (r < 40) op = ptfs_pkg::REQ_REMOVE;
    else if (r < 75) op = ptfs_pkg::REQ_FLAG;
    else             op = ptfs_pkg::REQ_SERVICE;
    if (op != ptfs_pkg::REQ_SERVICE && $urandom_range(0, 99) < 85)
      s = ptfs_pkg::SLOT_W'($urandom_range(0, ptfs_pkg::NUM_SLOTS - 1));
    else
      s = ptfs_pkg::SLOT_W'($urandom_range(0, 255));
    send_request(op, s);
  endtask

  // result side: check, then pick the next stall
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(accepted, run_slot);
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_now = quiet ? 1'b0 : ($urandom_range(0, 99) < 40);
      stall_left = pick_len();
    end
    res_stall <= stall_now;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_request(ptfs_pkg::REQ_ADD, 8'd0);
    send_request(ptfs_pkg::REQ_ADD, 8'd0);
    send_request(ptfs_pkg::REQ_ADD, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS - 1));
    send_request(ptfs_pkg::REQ_ADD, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS));
    send_request(ptfs_pkg::REQ_ADD, 8'd255);
    send_request(ptfs_pkg::REQ_FLAG, 8'd0);
    send_request(ptfs_pkg::REQ_FLAG, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS - 1));
    send_request(ptfs_pkg::REQ_FLAG, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS - 1));
    send_request(ptfs_pkg::REQ_FLAG, 8'd3);
    send_request(ptfs_pkg::REQ_FLAG, 8'd128);
    send_request(ptfs_pkg::REQ_SERVICE, 8'd255);
    send_request(ptfs_pkg::REQ_SERVICE, 8'd0);
    send_request(ptfs_pkg::REQ_SERVICE, 8'h5a);
    send_request(ptfs_pkg::REQ_SERVICE, 8'ha5);
    send_request(ptfs_pkg::REQ_REMOVE, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS - 1));
    send_request(ptfs_pkg::REQ_REMOVE, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS - 1));
    send_request(ptfs_pkg::REQ_REMOVE, 8'd255);
    send_request(ptfs_pkg::REQ_REMOVE, ptfs_pkg::SLOT_W'(ptfs_pkg::NUM_SLOTS));
    send_request(ptfs_pkg::REQ_FLAG, 8'd0);
    send_request(ptfs_pkg::REQ_REMOVE, 8'd0);
    send_request(ptfs_pkg::REQ_SERVICE, 8'd0);

    // back to back on one slot, then remove with work pending
    quiet = 1'b1;
    send_request(ptfs_pkg::REQ_ADD, 8'd7);
    repeat (3) send_request(ptfs_pkg::REQ_FLAG, 8'd7);
    send_request(ptfs_pkg::REQ_SERVICE, 8'd0);
    send_request(ptfs_pkg::REQ_FLAG, 8'd7);
    send_request(ptfs_pkg::REQ_FLAG, 8'd7);
    send_request(ptfs_pkg::REQ_REMOVE, 8'd7);
    send_request(ptfs_pkg::REQ_SERVICE, 8'd0);

    // random, with quiet stretches
    for (int i = 0; i < 1300; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random();
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected.size() != 0)
      $error("%0d results never arrived", sb.expected.size());
    if (sb.fails == 0 && sb.expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== priority_task_flag_scheduler.f =====
design/ptfs_pkg.sv
design/ptfs_pick.sv
design/ptfs_table.sv
design/priority_task_flag_scheduler.sv
dv/tb.sv
